### design/eatrm_pkg.sv
// shared constants, types and helpers for the euler angle to rotation matrix block
package eatrm_pkg;

   // number of cordic iterations (one pipeline stage each)
   localparam int CordicStages = 16;
   localparam int TableLen     = 24;
   localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;

   // q30 datapath width: values stay well inside +-4.0
   localparam int DataW = 34;
   // width of products of two q30 values
   localparam int ProdW = 2 * DataW;

   localparam logic signed [DataW-1:0] PiQ30 = 34'sd3373259426;

   typedef logic signed [DataW-1:0] q30_type;
   typedef logic signed [17:0]      q16_type;

   // sine and cosine of one angle
   typedef struct packed {
      q30_type sn;
      q30_type cs;
   } sincos_type;

   // atan(2^-i) in q30 radians
   function automatic q30_type atan_q30(input int idx);
      logic [31:0] t;
      unique case (idx)
         0:  t = 32'h3243F6A8;
         1:  t = 32'h1DAC6705;
         2:  t = 32'h0FADBAFC;
         3:  t = 32'h07F56EA6;
         4:  t = 32'h03FEAB76;
         5:  t = 32'h01FFD55B;
         6:  t = 32'h00FFFAAA;
         7:  t = 32'h007FFF55;
         8:  t = 32'h003FFFEA;
         9:  t = 32'h001FFFFD;
         10: t = 32'h000FFFFF;
         11: t = 32'h0007FFFF;
         12: t = 32'h0003FFFF;
         13: t = 32'h0001FFFF;
         14: t = 32'h0000FFFF;
         15: t = 32'h00007FFF;
         16: t = 32'h00003FFF;
         17: t = 32'h00001FFF;
         18: t = 32'h00000FFF;
         19: t = 32'h000007FF;
         20: t = 32'h000003FF;
         21: t = 32'h000001FF;
         22: t = 32'h000000FF;
         23: t = 32'h0000007F;
         default: t = 32'h0;
      endcase
      return q30_type'({2'b00, t});
   endfunction

   // integer square root, elaboration time only
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = v_in;
      res = 64'd0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // square root of the cordic gain product in q30, elaboration time only
   function automatic logic [63:0] gain_root();
      logic [63:0] p;
      logic [63:0] s;
      p = 64'd1 << 30;
      for (int i = 0; i < NumStages; i++) p = p + (p >> (2 * i));
      s = isqrt64(p << 30);
      if (s == 64'd0) s = 64'd1;
      return s;
   endfunction

   // cordic gain compensation in q30
   localparam logic [63:0] GainRoot = gain_root();
   localparam logic [63:0] GainWide = (64'd1 << 60) / GainRoot;
   localparam q30_type     GainQ30  = q30_type'(GainWide[DataW-1:0]);

   // q30 product with round half up
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [ProdW-1:0] p;
      p = ProdW'(a) * ProdW'(b) + (ProdW'(1) <<< 29);
      return q30_type'(p >>> 30);
   endfunction

   // q30 to q16 with round half up and saturation to +-1.0
   function automatic q16_type to_out(input q30_type v);
      q30_type r;
      r = (v + q30_type'(1 <<< 13)) >>> 14;
      if (r > q30_type'(65536)) r = q30_type'(65536);
      else if (r < -q30_type'(65536)) r = -q30_type'(65536);
      return q16_type'(r[17:0]);
   endfunction

endpackage

### design/eatrm_cordic.sv
// pipelined rotation mode cordic producing sine and cosine of one binary angle
module eatrm_cordic (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [15:0]        angle,
   output eatrm_pkg::sincos_type     result
);
   import eatrm_pkg::*;

   q30_type x_ff [NumStages+1];
   q30_type y_ff [NumStages+1];
   q30_type z_ff [NumStages+1];
   logic    neg_ff [NumStages+1];

   // quadrant fold and radian scaling at the entry
   logic signed [16:0] fold;
   logic               fold_neg;
   logic signed [50:0] zprod;
   always_comb begin
      fold     = 17'(angle);
      fold_neg = 1'b0;
      if (angle > 16'sd16384) begin
         fold     = 17'(angle) - 17'sd32768;
         fold_neg = 1'b1;
      end else if (angle < -16'sd16384) begin
         fold     = 17'(angle) + 17'sd32768;
         fold_neg = 1'b1;
      end
      zprod = 51'(fold) * 51'(PiQ30);
   end

   // divide by 32768 truncating toward zero
   q30_type z_in;
   always_comb begin
      if (zprod < 0) z_in = q30_type'(-((-zprod) >>> 15));
      else           z_in = q30_type'(zprod >>> 15);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= GainQ30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= fold_neg;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
      end
   end

   // undo the fold
   always_comb begin
      result.cs = neg_ff[NumStages] ? -x_ff[NumStages] : x_ff[NumStages];
      result.sn = neg_ff[NumStages] ? -y_ff[NumStages] : y_ff[NumStages];
   end

endmodule

### design/eatrm_matrix.sv
// three stage product and sum pipeline forming the nine matrix entries
module eatrm_matrix (
   input  logic                  clock,
   input  logic                  enable,
   input  eatrm_pkg::sincos_type yaw,
   input  eatrm_pkg::sincos_type pitch,
   input  eatrm_pkg::sincos_type roll,
   output eatrm_pkg::q16_type    m_out [9]
);
   import eatrm_pkg::*;

   // stage a: pair products
   q30_type spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, cpsr_ff, cpcr_ff;
   q30_type sp_ff, sy_a_ff, cy_a_ff, sr_a_ff, cr_a_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         spcy_ff <= mul30(pitch.sn, yaw.cs);
         spsy_ff <= mul30(pitch.sn, yaw.sn);
         cpcy_ff <= mul30(pitch.cs, yaw.cs);
         cpsy_ff <= mul30(pitch.cs, yaw.sn);
         cpsr_ff <= mul30(pitch.cs, roll.sn);
         cpcr_ff <= mul30(pitch.cs, roll.cs);
         sp_ff   <= pitch.sn;
         sy_a_ff <= yaw.sn;
         cy_a_ff <= yaw.cs;
         sr_a_ff <= roll.sn;
         cr_a_ff <= roll.cs;
      end
   end

   // stage b: triple and cross products
   q30_type t_ff [8];
   q30_type s_ff [5];
   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff[0] <= mul30(sr_a_ff, spcy_ff);
         t_ff[1] <= mul30(cr_a_ff, sy_a_ff);
         t_ff[2] <= mul30(sr_a_ff, spsy_ff);
         t_ff[3] <= mul30(cr_a_ff, cy_a_ff);
         t_ff[4] <= mul30(cr_a_ff, spcy_ff);
         t_ff[5] <= mul30(sr_a_ff, sy_a_ff);
         t_ff[6] <= mul30(cr_a_ff, spsy_ff);
         t_ff[7] <= mul30(sr_a_ff, cy_a_ff);
         s_ff[0] <= cpcy_ff;
         s_ff[1] <= -cpsy_ff;
         s_ff[2] <= sp_ff;
         s_ff[3] <= -cpsr_ff;
         s_ff[4] <= cpcr_ff;
      end
   end

   // stage c: sums, rounding and clamping
   q16_type m_ff [9];
   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff[0] <= to_out(s_ff[0]);
         m_ff[1] <= to_out(s_ff[1]);
         m_ff[2] <= to_out(s_ff[2]);
         m_ff[3] <= to_out(t_ff[0] + t_ff[1]);
         m_ff[4] <= to_out(t_ff[3] - t_ff[2]);
         m_ff[5] <= to_out(s_ff[3]);
         m_ff[6] <= to_out(t_ff[5] - t_ff[4]);
         m_ff[7] <= to_out(t_ff[6] + t_ff[7]);
         m_ff[8] <= to_out(s_ff[4]);
      end
   end

   assign m_out = m_ff;

endmodule

### design/euler_angles_to_rotation_matrix_top.sv
// top level: three cordic pipelines, matrix pipeline and valid/stall control
// Converts yaw, pitch and roll binary angles (65536 = full circle) into the nine
// entries of the rotation matrix in signed Q1.16, rounded and clamped to +-1.0.
// A new transaction may be accepted every cycle while the output is not stalled; the
// pipeline has one fold/scale stage, one stage per cordic iteration and three product
// and sum stages. The whole pipeline advances together whenever the output register is
// empty or being taken, so a stalled result holds every stage in place.
module euler_angles_to_rotation_matrix_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_m00,
   output logic signed [17:0] rsp_m01,
   output logic signed [17:0] rsp_m02,
   output logic signed [17:0] rsp_m10,
   output logic signed [17:0] rsp_m11,
   output logic signed [17:0] rsp_m12,
   output logic signed [17:0] rsp_m20,
   output logic signed [17:0] rsp_m21,
   output logic signed [17:0] rsp_m22
);
   import eatrm_pkg::*;

   localparam int Depth = NumStages + 4;

   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   logic             enable;

   // advance when the last stage is empty or its transaction is taken
   assign enable    = !valid_ff[Depth-1] || rsp_ready;
   assign req_ready = enable;
   assign valid_in  = {valid_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   sincos_type yaw_sc, pitch_sc, roll_sc;
   q16_type    m [9];

   eatrm_cordic u_yaw   (.clock(clock), .enable(enable), .angle(req_yaw_angle),
                         .result(yaw_sc));
   eatrm_cordic u_pitch (.clock(clock), .enable(enable), .angle(req_pitch_angle),
                         .result(pitch_sc));
   eatrm_cordic u_roll  (.clock(clock), .enable(enable), .angle(req_roll_angle),
                         .result(roll_sc));

   eatrm_matrix u_matrix (
      .clock (clock),
      .enable(enable),
      .yaw   (yaw_sc),
      .pitch (pitch_sc),
      .roll  (roll_sc),
      .m_out (m)
   );

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_m00   = m[0];
   assign rsp_m01   = m[1];
   assign rsp_m02   = m[2];
   assign rsp_m10   = m[3];
   assign rsp_m11   = m[4];
   assign rsp_m12   = m[5];
   assign rsp_m20   = m[6];
   assign rsp_m21   = m[7];
   assign rsp_m22   = m[8];

endmodule

### verif/testbench.sv
// testbench for the euler angle to rotation matrix block: predicts and checks every matrix
`timescale 1ns / 1ps

module testbench;

   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } angles_type;

   typedef struct packed {
      logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_yaw_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [17:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [17:0] rsp_m20, rsp_m21, rsp_m22;

   angles_type pending_angles[$];
   matrix_type expected_matrices[$];
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int mismatch_count = 0;
   bit stimulus_done = 1'b0;
   // acceptance seen at the last rising edge
   bit req_ready_seen = 1'b0;

   euler_angles_to_rotation_matrix_top dut (.*);

   always #4 clock = ~clock;

   // atan(2^-i) in q30 radians
   function automatic wide_type arctan_step(input int i);
      wide_type steps[24] = '{
         64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
         64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
         64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
         64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return steps[i];
   endfunction

   function automatic int stage_total();
      return (eatrm_pkg::CordicStages > 24) ? 24 : eatrm_pkg::CordicStages;
   endfunction

   // cordic gain compensation, 1/prod sqrt(1 + 2^-2i)
   function automatic wide_type cordic_gain();
      logic [63:0] p, v, root, b;
      p = 64'd1 << 30;
      for (int i = 0; i < stage_total(); i++) p = p + (p >> (2 * i));
      v = p << 30;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      if (root == 0) root = 1;
      return wide_type'((64'd1 << 60) / root);
   endfunction

   // sine and cosine in q30 with quadrant fold
   function automatic void angle_sincos(input logic signed [15:0] ang, output wide_type sn,
                                        output wide_type cs);
      wide_type a, x, y, z, nx;
      bit flip;
      a = ang;
      flip = 1'b0;
      if (a > 16384) begin
         a = a - 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a = a + 32768;
         flip = 1'b1;
      end
      z = (a * 64'sd3373259426) / 64'sd32768;
      x = cordic_gain();
      y = 0;
      for (int i = 0; i < stage_total(); i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan_step(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan_step(i);
         end
         x = nx;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function automatic wide_type q30_product(input wide_type a, input wide_type b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [17:0] q16_clamp(input wide_type v);
      wide_type r;
      r = (v + 64'sd8192) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r[17:0];
   endfunction

   function automatic matrix_type rotation_of(input angles_type t);
      wide_type sy, cy, sp, cp, sr, cr, spcy, spsy;
      matrix_type m;
      angle_sincos(t.yaw, sy, cy);
      angle_sincos(t.pitch, sp, cp);
      angle_sincos(t.roll, sr, cr);
      spcy = q30_product(sp, cy);
      spsy = q30_product(sp, sy);
      m.m00 = q16_clamp(q30_product(cp, cy));
      m.m01 = q16_clamp(-q30_product(cp, sy));
      m.m02 = q16_clamp(sp);
      m.m10 = q16_clamp(q30_product(sr, spcy) + q30_product(cr, sy));
      m.m11 = q16_clamp(-q30_product(sr, spsy) + q30_product(cr, cy));
      m.m12 = q16_clamp(-q30_product(cp, sr));
      m.m20 = q16_clamp(-q30_product(cr, spcy) + q30_product(sr, sy));
      m.m21 = q16_clamp(q30_product(cr, spsy) + q30_product(sr, cy));
      m.m22 = q16_clamp(q30_product(cp, cr));
      return m;
   endfunction

   // driver: present next angle triple, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_yaw_angle <= pending_angles[0].yaw;
               req_pitch_angle <= pending_angles[0].pitch;
               req_roll_angle <= pending_angles[0].roll;
               void'(pending_angles.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // record accepted transactions and their predicted matrices
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_matrices.push_back(
            rotation_of('{req_yaw_angle, req_pitch_angle, req_roll_angle}));
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (expected_matrices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_matrices.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   function automatic logic signed [15:0] random_angle();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(($urandom_range(3) * 16384) + $urandom_range(2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] corner[10] = '{16'sh8000, 16'sh7FFF, 0, 16384, -16384,
                                         16385, -16385, 8192, -1, 16'sh5555};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, quadrant boundaries, minus pi
      for (int i = 0; i < 10; i++)
         pending_angles.push_back('{corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]});
      for (int i = 0; i < 10; i++)
         pending_angles.push_back('{corner[i], corner[i], corner[i]});
      // random in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 77 : 0;
         take_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 20 : 0;
         repeat (150) pending_angles.push_back('{random_angle(), random_angle(),
                                                  random_angle()});
         while (pending_angles.size() > 0) @(posedge clock);
      end
      while (req_valid) @(posedge clock);
      while (expected_matrices.size() > 0) @(posedge clock);
      repeat (eatrm_pkg::CordicStages + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_matrices.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
